// ===== src/swq_pkg.sv =====
// swq_pkg: shared types and constants for the skin weight quantizer
// no dependencies

package swq_pkg;

    localparam int LANES  = 4;
    localparam int W_W    = 31;
    localparam int TOT_W  = 33;
    localparam int NUM_W  = 43;
    localparam int DEN_W  = 35;
    localparam int Q_W    = 8;
    localparam int DIV_ST = Q_W;
    localparam logic [9:0] Q_SCALE = 10'd510;
    localparam logic [Q_W-1:0] Q_FULL = 8'd255;

    typedef struct packed {
        logic signed [31:0] weight_a;
        logic signed [31:0] weight_b;
        logic signed [31:0] weight_c;
        logic signed [31:0] weight_d;
        logic signed [31:0] bone_a;
        logic signed [31:0] bone_b;
        logic signed [31:0] bone_c;
        logic signed [31:0] bone_d;
    } t_in;

    typedef struct packed {
        logic [7:0] qweight_a;
        logic [7:0] qweight_b;
        logic [7:0] qweight_c;
        logic [7:0] qweight_d;
        logic [7:0] index_out_a;
        logic [7:0] index_out_b;
        logic [7:0] index_out_c;
        logic [7:0] index_out_d;
    } t_out;

    function automatic logic [7:0] clamp_index(input logic signed [31:0] v);
        logic [7:0] r;
        if (v[31]) begin
            r = 8'd0;
        end else if (v > 32'sd255) begin
            r = 8'd255;
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

// ===== src/swq_in_if.sv =====
// swq_in_if: valid/ready channel for one vertex of weights and indices
// depends on swq_pkg

interface swq_in_if import swq_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/swq_out_if.sv =====
// swq_out_if: valid/ready channel for one quantized vertex
// depends on swq_pkg

interface swq_out_if import swq_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/swq_div_lane.sv =====
// swq_div_lane: pipelined restoring divider, one quotient bit per stage
// depends on swq_pkg

module swq_div_lane import swq_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quot
);

    logic [NUM_W-1:0] r_rem [1:DIV_ST-1];
    logic [DEN_W-1:0] r_den [1:DIV_ST-1];
    logic [Q_W-1:0]   r_q   [1:DIV_ST];

    for (genvar s = 0; s < DIV_ST; s++) begin : g_st
        localparam int K = DIV_ST - 1 - s;
        logic [NUM_W-1:0] n_rem;
        logic [DEN_W-1:0] n_den;
        logic [Q_W-1:0]   n_qin;
        logic [NUM_W-1:0] n_sh;
        logic             n_ge;
        if (s == 0) begin : g_head
            assign n_rem = i_num;
            assign n_den = i_den;
            assign n_qin = '0;
        end else begin : g_body
            assign n_rem = r_rem[s];
            assign n_den = r_den[s];
            assign n_qin = r_q[s];
        end
        assign n_sh = NUM_W'(n_den) << K;
        assign n_ge = n_rem >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[s+1] <= n_qin | (Q_W'(n_ge) << K);
            end
        end
        if (s < DIV_ST - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s+1] <= n_ge ? n_rem - n_sh : n_rem;
                    r_den[s+1] <= n_den;
                end
            end
        end
    end

    assign o_quot = r_q[DIV_ST];

endmodule

// ===== src/skin_weight_quantizer_top.sv =====
// skin_weight_quantizer_top: four skin weights to 8-bit weights summing to 255
// depends on swq_pkg, swq_in_if, swq_out_if, swq_div_lane
//
//  channel | dir | payload
//  i_in    | in  | weight_a..d (Q15.16), bone_a..d
//  o_out   | out | qweight_a..d, index_out_a..d
//
// one vertex per cycle while the output is not stalled; stages: clamp and total, numerator,
// eight divider stages (one quotient bit each), correction into output register
// reset clears all valid bits; payload registers are not reset
// a stall at the output holds every stage; nothing is dropped or repeated

module skin_weight_quantizer_top import swq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swq_in_if.sink    i_in,
    swq_out_if.source o_out
);

    localparam int NST = DIV_ST + 2;

    logic             n_en;
    logic             r_v    [0:NST-1];
    logic             r_zero [0:NST-1];
    logic [7:0]       r_idx  [0:NST-1][LANES];
    logic [W_W-1:0]   r_w    [LANES];
    logic [TOT_W-1:0] r_tot;
    logic [NUM_W-1:0] r_num  [LANES];
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   n_quot [LANES];
    logic [W_W-1:0]   n_w    [LANES];
    logic [TOT_W-1:0] n_tot;
    logic             r_ov;
    t_out             r_out;

    assign n_en       = !r_ov || o_out.ready;
    assign i_in.ready = n_en;

    always_comb begin
        n_w[0] = i_in.data.weight_a[31] ? '0 : i_in.data.weight_a[W_W-1:0];
        n_w[1] = i_in.data.weight_b[31] ? '0 : i_in.data.weight_b[W_W-1:0];
        n_w[2] = i_in.data.weight_c[31] ? '0 : i_in.data.weight_c[W_W-1:0];
        n_w[3] = i_in.data.weight_d[31] ? '0 : i_in.data.weight_d[W_W-1:0];
        n_tot  = TOT_W'(n_w[0]) + TOT_W'(n_w[1]) + TOT_W'(n_w[2]) + TOT_W'(n_w[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) begin
                r_v[s] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (n_en) begin
            r_v[0] <= i_in.valid;
            for (int s = 1; s < NST; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_w         <= n_w;
            r_tot       <= n_tot;
            r_zero[0]   <= n_tot == '0;
            r_idx[0][0] <= clamp_index(i_in.data.bone_a);
            r_idx[0][1] <= clamp_index(i_in.data.bone_b);
            r_idx[0][2] <= clamp_index(i_in.data.bone_c);
            r_idx[0][3] <= clamp_index(i_in.data.bone_d);
            for (int l = 0; l < LANES; l++) begin
                r_num[l] <= NUM_W'(r_w[l]) * NUM_W'(Q_SCALE) + NUM_W'(r_tot);
            end
            r_den <= DEN_W'({r_tot, 1'b0});
            for (int s = 1; s < NST; s++) begin
                r_zero[s] <= r_zero[s-1];
                r_idx[s]  <= r_idx[s-1];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        swq_div_lane u_div (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_num  (r_num[l]),
            .i_den  (r_den),
            .o_quot (n_quot[l])
        );
    end

    logic [9:0]       n_acc;
    logic [1:0]       n_last;
    logic signed [11:0] n_adj;
    logic [Q_W-1:0]   n_q [LANES];

    always_comb begin
        n_acc  = 10'(n_quot[0]) + 10'(n_quot[1]) + 10'(n_quot[2]) + 10'(n_quot[3]);
        n_last = 2'd0;
        for (int l = 0; l < LANES; l++) begin
            if (n_quot[l] != '0) begin
                n_last = 2'(l);
            end
        end
        n_adj = 12'(n_quot[n_last]) + 12'sd255 - 12'(n_acc);
        n_q   = n_quot;
        if (n_adj < 0) begin
            n_q[n_last] = '0;
        end else if (n_adj > 12'sd255) begin
            n_q[n_last] = Q_FULL;
        end else begin
            n_q[n_last] = n_adj[Q_W-1:0];
        end
        if (r_zero[NST-1]) begin
            n_q[0] = Q_FULL;
            n_q[1] = '0;
            n_q[2] = '0;
            n_q[3] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_out.qweight_a   <= n_q[0];
            r_out.qweight_b   <= n_q[1];
            r_out.qweight_c   <= n_q[2];
            r_out.qweight_d   <= n_q[3];
            r_out.index_out_a <= r_idx[NST-1][0];
            r_out.index_out_b <= r_idx[NST-1][1];
            r_out.index_out_c <= r_idx[NST-1][2];
            r_out.index_out_d <= r_idx[NST-1][3];
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

endmodule

// ===== src/swq_checker.sv =====
// swq_checker: port-level checks for skin_weight_quantizer_top, bound to it
// depends on swq_pkg

module swq_checker import swq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("output changed during stall");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while pipeline stalled");

    a_free_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused with empty output");

endmodule

bind skin_weight_quantizer_top swq_checker u_swq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ===== sim/swq_checker.sv =====
// swq_scoreboard: predicts the quantized weights and clamped indices for every input transfer
// and compares them with output transfers; depends on swq_pkg

module swq_scoreboard import swq_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_ready,
    input  t_in    i_in_data,
    input  logic   i_out_valid,
    input  logic   i_out_ready,
    input  t_out   i_out_data,
    output int     o_fail_count,
    output int     o_pending
);

    t_out vertex_q[$];

    function automatic logic [31:0] pos_weight(logic signed [31:0] v);
        return v[31] ? 32'd0 : v;
    endfunction

    function automatic logic [7:0] sat_index(logic signed [31:0] v);
        if (v[31]) return 8'd0;
        if (v > 32'sd255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic t_out quantize_vertex(t_in x);
        logic [63:0] w[4];
        logic [63:0] q[4];
        logic [63:0] total;
        logic [63:0] acc;
        longint      adj;
        int          last;
        t_out        r;
        w[0] = pos_weight(x.weight_a);
        w[1] = pos_weight(x.weight_b);
        w[2] = pos_weight(x.weight_c);
        w[3] = pos_weight(x.weight_d);
        total = w[0] + w[1] + w[2] + w[3];
        if (total == 0) begin
            q[0] = 255; q[1] = 0; q[2] = 0; q[3] = 0;
        end else begin
            acc = 0;
            last = 0;
            for (int i = 0; i < 4; i++) begin
                q[i] = (64'd510 * w[i] + total) / (64'd2 * total);
                if (q[i] > 255) q[i] = 255;
                acc += q[i];
                if (q[i] > 0) last = i;
            end
            if (acc != 255) begin
                adj = longint'(q[last]) + 255 - longint'(acc);
                if (adj < 0) adj = 0;
                if (adj > 255) adj = 255;
                q[last] = adj;
            end
        end
        r.qweight_a = q[0][7:0];
        r.qweight_b = q[1][7:0];
        r.qweight_c = q[2][7:0];
        r.qweight_d = q[3][7:0];
        r.index_out_a = sat_index(x.bone_a);
        r.index_out_b = sat_index(x.bone_b);
        r.index_out_c = sat_index(x.bone_c);
        r.index_out_d = sat_index(x.bone_d);
        return r;
    endfunction

    initial o_fail_count = 0;
    assign o_pending = vertex_q.size();

    always @(posedge i_clk) begin
        t_out exp_v;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                vertex_q.push_back(quantize_vertex(i_in_data));
            end
            if (i_out_valid && i_out_ready) begin
                if (vertex_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected output transfer %h", i_out_data);
                    end
                end else begin
                    exp_v = vertex_q.pop_front();
                    if (exp_v !== i_out_data) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("mismatch qw %0d %0d %0d %0d idx %0d %0d %0d %0d",
                                i_out_data.qweight_a, i_out_data.qweight_b,
                                i_out_data.qweight_c, i_out_data.qweight_d,
                                i_out_data.index_out_a, i_out_data.index_out_b,
                                i_out_data.index_out_c, i_out_data.index_out_d);
                            $display("  expected qw %0d %0d %0d %0d idx %0d %0d %0d %0d",
                                exp_v.qweight_a, exp_v.qweight_b,
                                exp_v.qweight_c, exp_v.qweight_d,
                                exp_v.index_out_a, exp_v.index_out_b,
                                exp_v.index_out_c, exp_v.index_out_d);
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// tb_top: drives vertices into skin_weight_quantizer_top with random gaps and stalls
// depends on swq_pkg, swq_in_if, swq_out_if, swq_scoreboard and the block

module tb_top;
    import swq_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;

    swq_in_if  in_ch();
    swq_out_if out_ch();

    skin_weight_quantizer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    swq_scoreboard checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_in_ready(in_ch.ready), .i_in_data(in_ch.data),
        .i_out_valid(out_ch.valid), .i_out_ready(out_ch.ready), .i_out_data(out_ch.data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb_top failed");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic signed [31:0] rand_weight();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return -$signed({1'b0, $urandom_range(0, 1000)});
            2: return 32'sd0;
            3: return 32'sh7fffffff;
            4: return $urandom_range(0, 3);
            5: return $urandom_range(0, 32'h0000ffff);
            default: return $urandom_range(0, 32'h0010_0000);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_bone();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(250, 260);
            2: return -$signed({1'b0, $urandom_range(0, 5)});
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // output stall pattern, independent of the sender
    initial begin
        int n;
        out_ch.ready = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                n = gap_len();
                out_ch.ready = 1'b0;
                repeat (n) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
            if ($urandom_range(0, 40) == 0) begin
                repeat ($urandom_range(50, 150)) @(negedge i_clk);
            end
        end
    end

    task automatic send_vertex(input t_in v);
        int n;
        n = gap_len();
        if (n > 0) begin
            in_ch.valid = 1'b0;
            repeat (n) @(negedge i_clk);
        end
        in_ch.data = v;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_weights(input logic signed [31:0] a, b, c, d);
        t_in v;
        v.weight_a = a; v.weight_b = b; v.weight_c = c; v.weight_d = d;
        v.bone_a = rand_bone(); v.bone_b = rand_bone();
        v.bone_c = rand_bone(); v.bone_d = rand_bone();
        send_vertex(v);
    endtask

    initial begin
        t_in v;
        int  waited;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed corners
        send_weights(0, 0, 0, 0);
        send_weights(-1, 32'sh80000000, -5, 0);
        send_weights(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_weights(32'sh00010000, 0, 0, 0);
        send_weights(0, 0, 0, 32'sh00010000);
        send_weights(1, 1, 1, 0);
        send_weights(1, 1, 1, 1);
        send_weights(1, 1000000, 0, 0);
        send_weights(1, 1, 1, 32'sh7fffffff);
        send_weights(32'sh7fffffff, 1, 1, 1);
        send_weights(3, 3, 3, 3);
        send_weights(1, 2, 0, 0);
        send_weights(-1, 7, -1, 9);
        v = '0;
        v.weight_a = 32'sh10000;
        v.bone_a = 32'sh80000000; v.bone_b = 32'sh7fffffff;
        v.bone_c = 255; v.bone_d = 256;
        send_vertex(v);
        v.bone_a = -1; v.bone_b = 0; v.bone_c = 1; v.bone_d = 254;
        send_vertex(v);

        // wait for the pipeline to drain once
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);

        for (int i = 0; i < 1635; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                v.weight_a = $urandom(); v.weight_b = $urandom();
                v.weight_c = $urandom(); v.weight_d = $urandom();
                v.bone_a = $urandom(); v.bone_b = $urandom();
                v.bone_c = $urandom(); v.bone_d = $urandom();
                send_vertex(v);
            end else begin
                send_weights(rand_weight(), rand_weight(), rand_weight(), rand_weight());
            end
        end
        in_ch.valid = 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
